[hdl/i2cmts_pkg.sv]
// Package of shared types and constants for the I2C master transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

  // Default for the largest transfer length that a start accepts.
  localparam int unsigned MaxLengthDefault = 32'd65535;

  // Operation carried by each request.
  typedef enum logic [1:0] {
    OP_START_WRITE = 2'd0,
    OP_START_READ  = 2'd1,
    OP_ARM_RESTART = 2'd2,
    OP_STATUS      = 2'd3
  } opcode_e;

  // Densely renumbered controller status codes; codes 14 and 15 are unused.
  typedef enum logic [3:0] {
    ST_START      = 4'd0,
    ST_RESTART    = 4'd1,
    ST_ADDR_W_ACK = 4'd2,
    ST_ADDR_R_ACK = 4'd3,
    ST_TX_ACK     = 4'd4,
    ST_RX_ACK     = 4'd5,
    ST_RX_NACK    = 4'd6,
    ST_BUS_ERR    = 4'd7,
    ST_ARB_LOST   = 4'd8,
    ST_TX_NACK    = 4'd9,
    ST_ADDR_W_NACK = 4'd10,
    ST_ADDR_R_NACK = 4'd11,
    ST_NO_INFO    = 4'd12,
    ST_OTHER      = 4'd13
  } status_e;

  // Transfer phase.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ADDRESS  = 3'd1,
    PH_TRANSMIT = 3'd2,
    PH_RECEIVE  = 3'd3,
    PH_ERROR    = 3'd4
  } phase_e;

  // Ack or nack selection.
  localparam logic [1:0] AckNoChange = 2'd0;
  localparam logic [1:0] AckAssert   = 2'd1;
  localparam logic [1:0] AckNack     = 2'd2;

  // Interrupt enable control.
  localparam logic [1:0] IrqNoChange = 2'd0;
  localparam logic [1:0] IrqEnable   = 2'd1;
  localparam logic [1:0] IrqDisable  = 2'd2;

  // Transfer status reported with each result.
  localparam logic [1:0] XferIdle  = 2'd0;
  localparam logic [1:0] XferBusy  = 2'd1;
  localparam logic [1:0] XferError = 2'd2;

  // One input request.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] transfer_length;
    logic [3:0]  status_code;
    logic [7:0]  received_byte;
    logic [7:0]  transmit_byte;
  } req_t;

  // One result.
  typedef struct packed {
    logic        data_we;
    logic [7:0]  data_value;
    logic [1:0]  ack_action;
    logic        request_stop;
    logic        request_start;
    logic        clear_start;
    logic        clear_interrupt;
    logic        store_received;
    logic [15:0] buffer_offset;
    logic [1:0]  irq_control;
    logic        transfer_done;
    logic [1:0]  transfer_status;
  } res_t;

  // Sequencer state kept between requests.
  typedef struct packed {
    phase_e      phase;
    logic [15:0] bytes_to_send;
    logic [15:0] bytes_to_receive;
    logic [15:0] position;
    logic        rs_armed;
  } seq_state_t;

endpackage

`default_nettype wire

[hdl/i2cmts_step.sv]
// Combinational step logic: next sequencer state and result for one request.
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_step #(
  parameter int unsigned MaxLength = i2cmts_pkg::MaxLengthDefault
) (
  input  wire i2cmts_pkg::req_t       req_i,
  input  wire i2cmts_pkg::seq_state_t cur_i,
  input  wire logic [6:0]             slave_address_i,
  output      i2cmts_pkg::seq_state_t nxt_o,
  output      i2cmts_pkg::res_t       res_o
);

  i2cmts_pkg::opcode_e op;
  i2cmts_pkg::status_e stat;
  logic [15:0]         pos_inc;
  logic [15:0]         send_dec;
  logic [15:0]         recv_dec;
  logic                len_ok;
  logic                clear_irq;

  assign op   = i2cmts_pkg::opcode_e'(req_i.opcode);
  assign stat = i2cmts_pkg::status_e'(req_i.status_code);

  // Offset increment wraps at 16 bits; counters saturate at zero.
  assign pos_inc  = cur_i.position + 16'd1;
  assign send_dec = (cur_i.bytes_to_send != 16'd0) ? cur_i.bytes_to_send - 16'd1 : 16'd0;
  assign recv_dec = (cur_i.bytes_to_receive != 16'd0) ?
                    cur_i.bytes_to_receive - 16'd1 : 16'd0;
  assign len_ok   = (req_i.transfer_length != 16'd0) &&
                    ({16'd0, req_i.transfer_length} <= 32'(MaxLength));

  // Decode the request against the current phase.
  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    res_o.buffer_offset = cur_i.position;
    clear_irq = 1'b1;
    unique case (op)
      i2cmts_pkg::OP_START_WRITE, i2cmts_pkg::OP_START_READ: begin
        if (len_ok) begin
          nxt_o.position = 16'd0;
          res_o.buffer_offset = 16'd0;
          if (op == i2cmts_pkg::OP_START_WRITE) begin
            nxt_o.bytes_to_send    = req_i.transfer_length;
            nxt_o.bytes_to_receive = 16'd0;
            if (stat == i2cmts_pkg::ST_TX_ACK) begin
              res_o.request_stop    = 1'b1;
              res_o.clear_interrupt = 1'b1;
            end
          end else begin
            nxt_o.bytes_to_send    = 16'd0;
            nxt_o.bytes_to_receive = req_i.transfer_length;
            if (stat == i2cmts_pkg::ST_TX_ACK) begin
              res_o.clear_interrupt = 1'b1;
            end
          end
          nxt_o.phase         = i2cmts_pkg::PH_ADDRESS;
          res_o.request_start = 1'b1;
          res_o.irq_control   = i2cmts_pkg::IrqEnable;
        end
      end
      i2cmts_pkg::OP_ARM_RESTART: begin
        nxt_o.rs_armed = 1'b1;
      end
      i2cmts_pkg::OP_STATUS: begin
        unique case (stat)
          i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART: begin
            if (cur_i.phase == i2cmts_pkg::PH_ADDRESS) begin
              res_o.data_we    = 1'b1;
              res_o.data_value = {slave_address_i, (cur_i.bytes_to_send == 16'd0)};
            end
            res_o.clear_start = 1'b1;
          end
          i2cmts_pkg::ST_ADDR_W_ACK: begin
            res_o.data_we       = 1'b1;
            res_o.data_value    = req_i.transmit_byte;
            nxt_o.position      = pos_inc;
            nxt_o.bytes_to_send = send_dec;
            nxt_o.phase         = i2cmts_pkg::PH_TRANSMIT;
          end
          i2cmts_pkg::ST_ADDR_R_ACK: begin
            res_o.ack_action = (cur_i.bytes_to_receive > 16'd1) ?
                               i2cmts_pkg::AckAssert : i2cmts_pkg::AckNack;
            nxt_o.phase = i2cmts_pkg::PH_RECEIVE;
          end
          i2cmts_pkg::ST_TX_ACK: begin
            if (cur_i.phase == i2cmts_pkg::PH_TRANSMIT) begin
              if (cur_i.bytes_to_send != 16'd0) begin
                res_o.data_we       = 1'b1;
                res_o.data_value    = req_i.transmit_byte;
                nxt_o.position      = pos_inc;
                nxt_o.bytes_to_send = send_dec;
              end else begin
                // Last byte acknowledged: hand over to a repeated start or stop.
                if (cur_i.rs_armed) begin
                  nxt_o.rs_armed = 1'b0;
                  clear_irq      = 1'b0;
                end else begin
                  res_o.request_stop = 1'b1;
                end
                nxt_o.phase         = i2cmts_pkg::PH_IDLE;
                res_o.transfer_done = 1'b1;
              end
            end
          end
          i2cmts_pkg::ST_RX_ACK: begin
            res_o.store_received   = 1'b1;
            nxt_o.position         = pos_inc;
            nxt_o.bytes_to_receive = recv_dec;
            res_o.ack_action       = (recv_dec > 16'd1) ?
                                     i2cmts_pkg::AckAssert : i2cmts_pkg::AckNack;
          end
          i2cmts_pkg::ST_RX_NACK: begin
            if (cur_i.phase == i2cmts_pkg::PH_RECEIVE) begin
              res_o.store_received   = 1'b1;
              nxt_o.position         = pos_inc;
              nxt_o.bytes_to_receive = recv_dec;
              res_o.request_stop     = 1'b1;
              nxt_o.phase            = i2cmts_pkg::PH_IDLE;
              res_o.transfer_done    = 1'b1;
            end
          end
          i2cmts_pkg::ST_BUS_ERR, i2cmts_pkg::ST_ARB_LOST, i2cmts_pkg::ST_TX_NACK,
          i2cmts_pkg::ST_ADDR_W_NACK, i2cmts_pkg::ST_ADDR_R_NACK: begin
            nxt_o.rs_armed      = 1'b0;
            res_o.request_stop  = 1'b1;
            nxt_o.phase         = i2cmts_pkg::PH_ERROR;
            res_o.transfer_done = 1'b1;
          end
          i2cmts_pkg::ST_NO_INFO: begin
            clear_irq = 1'b0;
          end
          default: begin
            // Other and unused codes only clear the interrupt flag.
          end
        endcase
        res_o.clear_interrupt = clear_irq;
        if (nxt_o.phase == i2cmts_pkg::PH_IDLE || nxt_o.phase == i2cmts_pkg::PH_ERROR) begin
          res_o.irq_control = i2cmts_pkg::IrqDisable;
        end
      end
      default: begin
      end
    endcase
    // Status follows the phase after this request.
    if (nxt_o.phase == i2cmts_pkg::PH_ERROR) begin
      res_o.transfer_status = i2cmts_pkg::XferError;
    end else if (nxt_o.phase == i2cmts_pkg::PH_IDLE) begin
      res_o.transfer_status = i2cmts_pkg::XferIdle;
    end else begin
      res_o.transfer_status = i2cmts_pkg::XferBusy;
    end
  end

endmodule

`default_nettype wire

[hdl/i2c_master_transfer_sequencer_top.sv]
// Top level of the I2C master transfer sequencer: input stage, state and result register.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_ready_o  in_req_i   (i2cmts_pkg::req_t)
//   out       output     out_valid_o/out_ready_i out_res_o (i2cmts_pkg::res_t)
//   cfg       input      cfg_we_i               cfg_wdata_i (slave address)
//
// A request is registered in the input stage on acceptance and its result is then registered
// in the result register; one request is taken every cycle while the result is not stalled.
// The sequencer state is updated in the same cycle that the result is registered.
// A stalled result holds the input stage; a full input stage then drops in_ready_o.
// Reset returns the phase to idle and clears counters, offset and the restart flag.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transfer_sequencer_top #(
  parameter int unsigned MaxLength = i2cmts_pkg::MaxLengthDefault
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             in_valid_i,
  output       logic             in_ready_o,
  input  wire  i2cmts_pkg::req_t in_req_i,
  output       logic             out_valid_o,
  input  wire  logic             out_ready_i,
  output       i2cmts_pkg::res_t out_res_o,
  input  wire  logic             cfg_we_i,
  input  wire  logic [6:0]       cfg_wdata_i
);

  logic                   in_valid_q;
  i2cmts_pkg::req_t       in_req_q;
  logic                   out_valid_q;
  i2cmts_pkg::res_t       out_res_q;
  i2cmts_pkg::res_t       res_d;
  i2cmts_pkg::seq_state_t state_q;
  i2cmts_pkg::seq_state_t state_d;
  logic [6:0]             slave_address_q;
  logic                   advance;

  // The held request moves on when the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
  end

  // Slave address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= 7'd0;
    end else if (cfg_we_i) begin
      slave_address_q <= cfg_wdata_i;
    end
  end

  // Step logic.
  i2cmts_step #(
    .MaxLength(MaxLength)
  ) u_step (
    .req_i          (in_req_q),
    .cur_i          (state_q),
    .slave_address_i(slave_address_q),
    .nxt_o          (state_d),
    .res_o          (res_d)
  );

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: i2cmts_pkg::PH_IDLE, bytes_to_send: 16'd0,
                   bytes_to_receive: 16'd0, position: 16'd0, rs_armed: 1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // A held request that cannot move stays held.
  a_hold_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("held request was lost");

  // A finished or failed transfer never reports busy.
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.transfer_done) |->
      (out_res_q.transfer_status != i2cmts_pkg::XferBusy))
    else $error("completion reported while busy");

  // A start request enables the interrupt and leaves the sequencer in the address phase.
  a_start_enables_irq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.request_start) |=>
      (out_res_q.irq_control == i2cmts_pkg::IrqEnable &&
       state_q.phase == i2cmts_pkg::PH_ADDRESS))
    else $error("start without interrupt enable or address phase");

  // A byte is either written to the controller or stored, never both.
  a_write_or_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !(res_d.data_we && res_d.store_received))
    else $error("data write and store in one result");

endmodule

`default_nettype wire
